// File: rtl/arpr_pkg.sv
`default_nettype none
package arpr_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = 6;
    localparam int HDR_BYTES  = 42;

    localparam logic [2:0] CLS_NONE = 3'd0;
    localparam logic [2:0] CLS_DROP = 3'd1;
    localparam logic [2:0] CLS_ARP  = 3'd2;
    localparam logic [2:0] CLS_PASS = 3'd3;
    localparam logic [2:0] CLS_ETH  = 3'd4;
    localparam logic [2:0] CLS_IP   = 3'd5;
    localparam logic [2:0] CLS_UDP  = 3'd6;

    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    localparam logic [31:0] OWN_IP_RESET = 32'hC0A8_0302;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [5:0] pos;
        logic       rw;
        logic       last;
        logic [2:0] cls;
        logic [3:0] port;
    } t_meta;

endpackage
`default_nettype wire

// File: rtl/arpr_in_if.sv
`default_nettype none
interface arpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] ingress_port;

    modport source (output valid, data_byte, last_byte, ingress_port, input ready);
    modport sink   (input valid, data_byte, last_byte, ingress_port, output ready);
endinterface
`default_nettype wire

// File: rtl/arpr_out_if.sv
`default_nettype none
interface arpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       drop_frame;
    logic [3:0] egress_port;

    modport source (output valid, out_byte, out_last, drop_frame, egress_port, input ready);
    modport sink   (input valid, out_byte, out_last, drop_frame, egress_port, output ready);
endinterface
`default_nettype wire

// File: rtl/arp_responder_packet_reflector.sv
// ARP responder and frame reflector.
// i_in carries one frame word per accepted cycle (data, last flag, ingress
// port); o_out carries the rewritten frame words in original order with the
// drop flag and the egress port, which is the ingress port. Handshake on both
// channels is valid/ready. Configuration (own IP, own MAC) goes in on the
// write port and must only change while no frame is in flight.
// The first HOLD_BYTES words of a frame sit in a 64-entry ring RAM until the
// frame is classified; from then on one word leaves for every word that
// enters, passing through the RAM read register and then the output register.
// On the last word intake stops while the ring drains its held words, one word
// per cycle while the output is not stalled, and once the ring is empty the
// positions are cleared for the next frame.
// The single RAM read port sets that flush rate.
// A stalled receiver holds the output register and the word behind it, and
// intake stops until the pipeline moves again.
// Reset clears positions, class and the output valid; ring contents need no
// clearing, only words of the current frame are read back.
`default_nettype none
module arp_responder_packet_reflector
    import arpr_pkg::*;
#(
    parameter int HOLD_BYTES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    arpr_in_if.sink    i_in,
    arpr_out_if.source o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [47:0] i_cfg_data
);
    localparam logic [6:0] HOLD7 = 7'(HOLD_BYTES);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic [6:0]  r_seen;
    logic [6:0]  r_sent;
    logic [2:0]  r_cls;
    logic [3:0]  r_port;
    logic        r_hdr_done;
    logic        r_flush;
    t_hdr        r_hdr;
    t_hdr        n_hdr;
    logic        r_b_vld;
    t_meta       r_b_meta;
    logic        r_o_vld;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic        r_o_drop;
    logic [3:0]  r_o_port;

    logic        in_acc;
    logic        b_move;
    logic        can_issue;
    logic [6:0]  seen_nx;
    logic [7:0]  len;
    logic [2:0]  cls_calc;
    logic [2:0]  cls_step;
    logic [3:0]  port_now;
    logic        step_emit;
    logic        flush_issue;
    logic        flush_done;
    logic        issue;
    t_meta       meta;
    logic [7:0]  ram_rdata;
    logic [7:0]  rw_byte;

    assign b_move    = r_b_vld && (!r_o_vld || o_out.ready);
    assign can_issue = !r_b_vld || b_move;
    assign i_in.ready = !r_flush && can_issue;
    assign in_acc    = i_in.valid && i_in.ready;

    assign seen_nx  = r_seen + 7'd1;
    assign len      = {1'b0, r_seen} + 8'd1;
    assign port_now = (r_seen == 7'd0) ? i_in.ingress_port : r_port;

    // capture header words while the frame is still unclassified
    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            n_hdr[k] = (r_cls == CLS_NONE && r_seen == 7'(k)) ? i_in.data_byte : r_hdr[k];
        end
    end

    arpr_classify u_classify (
        .i_hdr    (n_hdr),
        .i_len    (len),
        .i_own_ip (r_own_ip),
        .o_cls    (cls_calc)
    );

    assign cls_step = (r_cls == CLS_NONE && (i_in.last_byte || seen_nx == HOLD7)) ?
                      cls_calc : r_cls;
    assign step_emit = in_acc && !i_in.last_byte && cls_step != CLS_NONE &&
                       (7'(seen_nx - r_sent) >= HOLD7);
    assign flush_issue = r_flush && can_issue && (r_sent != r_seen);
    assign flush_done  = r_flush && (r_sent == r_seen);
    assign issue       = step_emit || flush_issue;

    always_comb begin
        meta.pos  = r_sent[5:0];
        meta.rw   = !r_hdr_done && r_sent < 7'd42;
        meta.last = r_flush && (7'(r_sent + 7'd1) == r_seen);
        meta.cls  = r_flush ? r_cls : cls_step;
        meta.port = r_flush ? r_port : port_now;
    end

    arpr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_seen[RING_AW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_re    (issue),
        .i_raddr (r_sent[RING_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    arpr_rewrite u_rewrite (
        .i_byte    (ram_rdata),
        .i_meta    (r_b_meta),
        .i_hdr     (r_hdr),
        .i_own_ip  (r_own_ip),
        .i_own_mac (r_own_mac),
        .o_byte    (rw_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip   <= OWN_IP_RESET;
            r_own_mac  <= 48'd0;
            r_seen     <= 7'd0;
            r_sent     <= 7'd0;
            r_cls      <= CLS_NONE;
            r_port     <= 4'd0;
            r_hdr_done <= 1'b0;
            r_flush    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                    CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                    default:     r_own_ip  <= r_own_ip;
                endcase
            end
            if (in_acc) begin
                r_seen  <= seen_nx;
                r_cls   <= cls_step;
                r_port  <= port_now;
                r_flush <= i_in.last_byte;
            end
            if (issue) begin
                r_sent <= r_sent + 7'd1;
                if (r_sent == 7'd41) begin
                    r_hdr_done <= 1'b1;
                end
            end
            // drained: start the next frame from a clean position
            if (flush_done) begin
                r_seen     <= 7'd0;
                r_sent     <= 7'd0;
                r_cls      <= CLS_NONE;
                r_hdr_done <= 1'b0;
                r_flush    <= 1'b0;
            end
            if (issue) begin
                r_b_vld <= 1'b1;
            end else if (b_move) begin
                r_b_vld <= 1'b0;
            end
            if (b_move) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hdr <= n_hdr;
        end
        if (issue) begin
            r_b_meta <= meta;
        end
        if (b_move) begin
            r_o_byte <= rw_byte;
            r_o_last <= r_b_meta.last;
            r_o_drop <= (r_b_meta.cls == CLS_DROP);
            r_o_port <= r_b_meta.port;
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.out_byte    = r_o_byte;
    assign o_out.out_last    = r_o_last;
    assign o_out.drop_frame  = r_o_drop;
    assign o_out.egress_port = r_o_port;
endmodule
`default_nettype wire

// File: rtl/arpr_ram.sv
`default_nettype none
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/arpr_classify.sv
`default_nettype none
module arpr_classify
    import arpr_pkg::*;
(
    input  wire t_hdr        i_hdr,
    input  wire logic [7:0]  i_len,
    input  wire logic [31:0] i_own_ip,
    output logic      [2:0]  o_cls
);
    logic [15:0] etype;
    logic        has_type;

    assign etype    = {i_hdr[12], i_hdr[13]};
    assign has_type = (i_len >= 8'd14);

    always_comb begin
        if (has_type && etype == 16'h0806) begin
            if (i_len < 8'd42 || {i_hdr[20], i_hdr[21]} != 16'd1 ||
                {i_hdr[38], i_hdr[39], i_hdr[40], i_hdr[41]} != i_own_ip) begin
                o_cls = CLS_DROP;
            end else begin
                o_cls = CLS_ARP;
            end
        end else if (i_len < 8'd12) begin
            o_cls = CLS_PASS;
        end else if (has_type && etype == 16'h0800 && i_len >= 8'd34 &&
                     i_hdr[14][7:4] == 4'd4) begin
            o_cls = (i_hdr[23] == 8'd17 && i_len >= 8'd38) ? CLS_UDP : CLS_IP;
        end else begin
            o_cls = CLS_ETH;
        end
    end
endmodule
`default_nettype wire

// File: rtl/arpr_rewrite.sv
`default_nettype none
module arpr_rewrite
    import arpr_pkg::*;
(
    input  wire logic [7:0]  i_byte,
    input  wire t_meta       i_meta,
    input  wire t_hdr        i_hdr,
    input  wire logic [31:0] i_own_ip,
    input  wire logic [47:0] i_own_mac,
    output logic      [7:0]  o_byte
);
    logic [5:0] pos;
    logic [5:0] mac_k;
    logic [5:0] ip_k;

    assign pos = i_meta.pos;

    always_comb begin
        o_byte = i_byte;
        mac_k  = 6'd0;
        ip_k   = 6'd0;
        if (i_meta.rw) begin
            case (i_meta.cls)
                CLS_ARP: begin
                    if (pos < 6'd6) begin
                        o_byte = i_hdr[pos + 6'd6];
                    end else if (pos < 6'd12) begin
                        mac_k  = pos - 6'd6;
                        o_byte = i_own_mac[6'd47 - {mac_k[2:0], 3'b000} -: 8];
                    end else if (pos == 6'd20) begin
                        o_byte = 8'd0;
                    end else if (pos == 6'd21) begin
                        o_byte = 8'd2;
                    end else if (pos >= 6'd22 && pos < 6'd28) begin
                        mac_k  = pos - 6'd22;
                        o_byte = i_own_mac[6'd47 - {mac_k[2:0], 3'b000} -: 8];
                    end else if (pos >= 6'd28 && pos < 6'd32) begin
                        ip_k   = pos - 6'd28;
                        o_byte = i_own_ip[5'd31 - {ip_k[1:0], 3'b000} -: 8];
                    end else if (pos >= 6'd32) begin
                        // sender fields of the request become the target
                        o_byte = i_hdr[pos - 6'd10];
                    end
                end
                CLS_ETH, CLS_IP, CLS_UDP: begin
                    if (pos < 6'd6) begin
                        o_byte = i_hdr[pos + 6'd6];
                    end else if (pos < 6'd12) begin
                        o_byte = i_hdr[pos - 6'd6];
                    end else if (i_meta.cls != CLS_ETH && pos >= 6'd26 && pos < 6'd30) begin
                        o_byte = i_hdr[pos + 6'd4];
                    end else if (i_meta.cls != CLS_ETH && pos >= 6'd30 && pos < 6'd34) begin
                        o_byte = i_hdr[pos - 6'd4];
                    end else if (i_meta.cls == CLS_UDP && pos >= 6'd34 && pos < 6'd36) begin
                        o_byte = i_hdr[pos + 6'd2];
                    end else if (i_meta.cls == CLS_UDP && pos >= 6'd36 && pos < 6'd38) begin
                        o_byte = i_hdr[pos - 6'd2];
                    end
                end
                default: begin
                    o_byte = i_byte;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
